@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/m2s_pkg.sv @@
package m2s_pkg;

  localparam int WordW = 16;
  localparam int FracW = 4;
  localparam int ExpW  = 3;
  localparam int ClassW = 3;

  typedef enum logic [ClassW-1:0] {
    CLS_ZERO   = 3'd0,
    CLS_DENORM = 3'd1,
    CLS_NORMAL = 3'd2,
    CLS_INF    = 3'd3,
    CLS_NAN    = 3'd4
  } value_class_t;

  typedef enum logic {
    REG_FRACTION_BITS = 1'b0,
    REG_EXPONENT_BITS = 1'b1
  } reg_index_t;

  // Result word carried between modules.
  typedef struct packed {
    value_class_t value_class;
    logic         sign;
    logic [31:0]  single_bits;
  } result_t;

endpackage

@@ rtl/m2s_cfg.sv @@
module m2s_cfg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic                     cfg_index_hi,
  input  logic [m2s_pkg::FracW-1:0] cfg_data,
  output logic [m2s_pkg::FracW-1:0] frac_w,
  output logic [m2s_pkg::ExpW-1:0]  exp_w
);
  import m2s_pkg::*;

  logic [FracW-1:0] fraction_bits;
  logic [ExpW-1:0]  exponent_bits;

  assign cfg_ready = 1'b1;

  // Register writes; indexes above the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_bits <= FracW'(10);
      exponent_bits <= ExpW'(5);
    end else if (cfg_valid && !cfg_index_hi) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRACTION_BITS: fraction_bits <= cfg_data;
        REG_EXPONENT_BITS: exponent_bits <= cfg_data[ExpW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported widths.
  always_comb begin
    frac_w = fraction_bits;
    if (fraction_bits < FracW'(2)) frac_w = FracW'(2);
    else if (fraction_bits > FracW'(10)) frac_w = FracW'(10);
    exp_w = exponent_bits;
    if (exponent_bits < ExpW'(3)) exp_w = ExpW'(3);
    else if (exponent_bits > ExpW'(5)) exp_w = ExpW'(5);
  end
endmodule

@@ rtl/m2s_decode.sv @@
module m2s_decode (
  input  logic [m2s_pkg::WordW-1:0] word,
  input  logic [m2s_pkg::FracW-1:0] frac_w,
  input  logic [m2s_pkg::ExpW-1:0]  exp_w,
  output m2s_pkg::result_t          res
);
  import m2s_pkg::*;

  logic [9:0]  frac;
  logic [4:0]  expf;
  logic        sgn;
  logic [4:0]  emax;
  logic [7:0]  bias;
  logic [3:0]  p;
  logic [15:0] shifted;
  logic [7:0]  ex;
  logic [22:0] mant;
  logic [22:0] top;

  always_comb begin
    shifted = word >> frac_w;
    frac = 10'(word & ((16'd1 << frac_w) - 16'd1));
    expf = 5'(shifted & ((16'd1 << exp_w) - 16'd1));
    sgn  = shifted[exp_w];
    emax = 5'((6'd1 << exp_w) - 6'd1);
    bias = 8'((9'd1 << (exp_w - 3'd1)) - 9'd1);
    // Fraction aligned to the top of the single fraction field.
    top  = 23'({13'd0, frac} << (5'd23 - 5'(frac_w)));
    // Position of the top set fraction bit.
    p = '0;
    for (int i = 0; i < 10; i++) begin
      if (frac[i]) p = 4'(i);
    end
    res.sign = sgn;
    ex   = '0;
    mant = '0;
    if (expf == emax) begin
      ex = 8'hFF;
      if (frac == '0) begin
        res.value_class = CLS_INF;
      end else begin
        res.value_class = CLS_NAN;
        mant = top | 23'h400000;
      end
    end else if (expf == '0) begin
      if (frac == '0) begin
        res.value_class = CLS_ZERO;
      end else begin
        res.value_class = CLS_DENORM;
        ex = 8'(8'(p) + 8'd128 - bias - 8'(frac_w));
        mant = 23'({13'd0, frac & ~(10'd1 << p)} << (5'd23 - 5'(p)));
      end
    end else begin
      res.value_class = CLS_NORMAL;
      ex = 8'(8'(expf) + 8'd127 - bias);
      mant = top;
    end
    res.single_bits = {sgn, ex, mant};
  end
endmodule

@@ rtl/minifloat_to_single_converter.sv @@
// Channel | Direction | Handshake
// in      | input     | in_valid / in_ready, encoded_word
// out     | output    | out_valid / out_ready, value_class, sign, single_bits
// cfg     | input     | cfg_valid / cfg_ready, cfg_index, cfg_data
// One word per cycle while the output is not stalled; a result appears in the cycle after acceptance.
// The result is held in the single output register after the decode logic.
// A stalled output holds its word; a new word is taken when the register
// is empty or being read. Synchronous reset empties the output register.
module minifloat_to_single_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] encoded_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  value_class,
  output logic        sign,
  output logic [31:0] single_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import m2s_pkg::*;

  logic [FracW-1:0] frac_w;
  logic [ExpW-1:0]  exp_w;
  result_t          res_next;
  result_t          res;

  m2s_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready,
    .cfg_index(cfg_index[0:0]), .cfg_index_hi(cfg_index[1]),
    .cfg_data, .frac_w, .exp_w
  );

  m2s_decode u_dec (.word(encoded_word), .frac_w, .exp_w, .res(res_next));

  assign in_ready = !out_valid || out_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res <= res_next;
    end
  end

  assign value_class = res.value_class;
  assign sign        = res.sign;
  assign single_bits = res.single_bits;
endmodule

@@ rtl/m2s_checker.sv @@
`include "assert_macros.svh"
module m2s_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  value_class,
  input logic [31:0] single_bits
);
  `ASSERT_NEXT(a_in_to_out, clk, rst, in_valid && in_ready, out_valid, "accepted word lost")
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, $stable(single_bits), "stalled word changed")
  `ASSERT_IMPL(a_ready, clk, rst, !out_valid, in_ready, "input blocked while output empty")
  `ASSERT_IMPL(a_inf, clk, rst, out_valid && value_class == 3'd3, single_bits[30:0] == 31'h7F800000, "bad infinity")
endmodule

bind minifloat_to_single_converter m2s_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .value_class, .single_bits
);

@@ test/testbench.sv @@
module testbench;
  import m2s_pkg::*;

  localparam int CycleLimit = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] encoded_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  value_class;
  logic        sign;
  logic [31:0] single_bits;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  // Sink side controls, set by the stimulus process.
  bit          sink_random = 1'b1;
  int          sink_hold = 0;
  int unsigned cycle_count = 0;

  minifloat_to_single_converter i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected conversions, oldest first, plus a model of the format registers.
  class conversion_board;
    result_t     pending[$];
    int unsigned frac_reg = 10;
    int unsigned exp_reg = 5;
    int          error_count = 0;

    function void note_word(logic [15:0] word);
      int unsigned n, k, frac, expf, sgn, emax, bias, top;
      result_t r;
      n = (frac_reg < 2) ? 2 : (frac_reg > 10) ? 10 : frac_reg;
      k = (exp_reg < 3) ? 3 : (exp_reg > 5) ? 5 : exp_reg;
      frac = word & ((1 << n) - 1);
      expf = (word >> n) & ((1 << k) - 1);
      sgn = (word >> (n + k)) & 1;
      emax = (1 << k) - 1;
      bias = (1 << (k - 1)) - 1;
      top = 0;
      r.sign = sgn[0];
      r.single_bits = 32'(sgn) << 31;
      if (expf == emax) begin
        if (frac == 0) begin
          r.value_class = CLS_INF;
          r.single_bits |= 32'h7F80_0000;
        end else begin
          r.value_class = CLS_NAN;
          r.single_bits |= 32'h7FC0_0000 | (32'(frac) << (23 - n));
        end
      end else if (expf == 0) begin
        if (frac == 0) begin
          r.value_class = CLS_ZERO;
        end else begin
          // Normalize a denormal on its leading one.
          for (int i = 0; i < n; i++) if (frac[i]) top = i;
          r.value_class = CLS_DENORM;
          r.single_bits |= 32'((top + 128 - bias - n) & 8'hFF) << 23;
          r.single_bits |= (32'(frac ^ (1 << top)) << (23 - top)) & 32'h007F_FFFF;
        end
      end else begin
        r.value_class = CLS_NORMAL;
        r.single_bits |= 32'((expf + 127 - bias) & 8'hFF) << 23;
        r.single_bits |= 32'(frac) << (23 - n);
      end
      pending.push_back(r);
    endfunction

    function void check_word(logic [2:0] cls, logic sgn, logic [31:0] bits);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: class %0d bits %h", cls, bits);
        error_count++;
        return;
      end
      e = pending.pop_front();
      if (cls !== e.value_class) begin
        $error("value_class: expected %0d, got %0d", e.value_class, cls);
        error_count++;
      end
      if (sgn !== e.sign) begin
        $error("sign: expected %0d, got %0d", e.sign, sgn);
        error_count++;
      end
      if (bits !== e.single_bits) begin
        $error("single_bits: expected %h, got %h", e.single_bits, bits);
        error_count++;
      end
    endfunction
  endclass

  conversion_board board = new();

  // Sink: check accepted results and drive ready with random stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) board.check_word(value_class, sign, single_bits);
  end

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        sink_hold--;
      end else if (sink_random && gap == 0 && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        out_ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ready <= (gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one word, holding it until it is accepted. Valid stays high
  // between back-to-back words and drops only for a gap or a drain.
  task automatic send_word(logic [15:0] word, bit allow_gaps);
    if (allow_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    encoded_word <= word;
    do @(posedge clk); while (!in_ready);
    board.note_word(word);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [3:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRACTION_BITS) board.frac_reg = data;
    else board.exp_reg = data[2:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Directed words for the current format: both zeros, infinities, NaNs,
  // smallest and largest denormal, largest normal, and all-ones.
  task automatic directed_words();
    int unsigned n, k;
    n = board.frac_reg;
    k = board.exp_reg;
    for (int s = 0; s < 2; s++) begin
      send_word(16'(s << (n + k)), 1);
      send_word(16'((s << (n + k)) | (((1 << k) - 1) << n)), 1);
      send_word(16'((s << (n + k)) | (((1 << k) - 1) << n) | 1), 1);
      send_word(16'((s << (n + k)) | (((1 << k) - 1) << n) | ((1 << n) - 1)), 1);
      send_word(16'((s << (n + k)) | 1), 1);
      send_word(16'((s << (n + k)) | ((1 << n) - 1)), 1);
      send_word(16'((s << (n + k)) | (((1 << k) - 2) << n) | ((1 << n) - 1)), 1);
    end
    send_word(16'hFFFF, 1);
  endtask

  initial begin
    int unsigned fsel[4] = '{2, 10, 5, 7};
    int unsigned esel[4] = '{3, 5, 4, 3};
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Reset format first.
    directed_words();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_FRACTION_BITS, 4'(fsel[phase]));
      write_reg(REG_EXPONENT_BITS, 4'(esel[phase]));
      if (phase == 0) directed_words();
      for (int i = 0; i < 205; i++) begin
        // The last phase runs without gaps on either side.
        if (phase == 3) sink_random = 1'b0;
        if (phase == 1 && i == 20) sink_hold = 60;
        send_word(16'($urandom), phase != 3);
      end
      drain();
    end

    drain();
    if (board.pending.size() == 0 && board.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ minifloat_to_single_converter.f @@
+incdir+rtl
rtl/m2s_pkg.sv
rtl/m2s_cfg.sv
rtl/m2s_decode.sv
rtl/minifloat_to_single_converter.sv
rtl/m2s_checker.sv
test/testbench.sv
